### rtl/ssd_pkg.sv
package ssd_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = 17;
  localparam int DotW   = 36;
  localparam int DetW   = 74;
  localparam int EpsW   = 32;
  localparam int DistW  = 36;
  localparam int ParW   = 17;

  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [DotW-1:0]  dot_t;
  typedef logic signed [DetW-1:0]  det_t;

  function automatic logic near_zero(input det_t x, input logic [EpsW-1:0] eps);
    logic [DetW-1:0] m;
    m = x[DetW-1] ? (~x + 1'b1) : x;
    return m <= {{(DetW-EpsW){1'b0}}, eps};
  endfunction

endpackage

### rtl/ssd_div.sv
module ssd_div import ssd_pkg::*; #(
  parameter int FRAC = 16
) (
  input  logic            clk,
  input  logic            adv,
  input  logic [DetW-1:0] num,
  input  logic [DetW-1:0] den,
  input  logic            zero,
  output logic [FRAC:0]   quo
);
  localparam int QW = FRAC + 1;

  logic [DetW-1:0] rem [QW+1];
  logic [QW-1:0]   qv  [QW+1];
  logic [DetW-1:0] dv  [QW+1];

  always_comb begin
    rem[0] = num;
    qv[0]  = '0;
    dv[0]  = den;
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DetW:0] r2;
    logic [DetW:0] diff;
    always_comb begin
      r2   = (i == 0) ? {1'b0, rem[i]} : {rem[i], 1'b0};
      diff = r2 - {1'b0, dv[i]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!diff[DetW]) begin
          rem[i+1] <= diff[DetW-1:0];
          qv[i+1]  <= {qv[i][QW-2:0], 1'b1};
        end else begin
          rem[i+1] <= r2[DetW-1:0];
          qv[i+1]  <= {qv[i][QW-2:0], 1'b0};
        end
        dv[i+1] <= dv[i];
      end
    end
  end

  logic [FRAC:0] zsr;
  always_ff @(posedge clk) begin
    if (adv) zsr <= {zsr[FRAC-1:0], zero || (den == '0)};
  end

  assign quo = zsr[FRAC] ? '0 : qv[QW];
endmodule

### rtl/segment_segment_dist_sq_core.sv
// Squared closest distance between two 3D segments, one request per cycle when out_stall is low.
// Input channel: in_valid/in_stall with twelve signed 16-bit coordinates.
// Output channel: out_valid/out_stall with dist_sq, s_param, t_param.
// Config channel: cfg_valid/cfg_ready writes near_zero_eps; always ready.
// Pipeline: ten arithmetic stages plus the restoring divider, one quotient bit per stage.
// Throughput: one request per cycle when out_stall is low.
// Reset clears every stage valid bit and the epsilon register.
// A stall on the output freezes the whole pipeline; in_stall follows it.
module segment_segment_dist_sq_core import ssd_pkg::*; #(
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CoordW-1:0] seg1_start_x,
  input  logic signed [CoordW-1:0] seg1_start_y,
  input  logic signed [CoordW-1:0] seg1_start_z,
  input  logic signed [CoordW-1:0] seg1_end_x,
  input  logic signed [CoordW-1:0] seg1_end_y,
  input  logic signed [CoordW-1:0] seg1_end_z,
  input  logic signed [CoordW-1:0] seg2_start_x,
  input  logic signed [CoordW-1:0] seg2_start_y,
  input  logic signed [CoordW-1:0] seg2_start_z,
  input  logic signed [CoordW-1:0] seg2_end_x,
  input  logic signed [CoordW-1:0] seg2_end_y,
  input  logic signed [CoordW-1:0] seg2_end_z,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [EpsW-1:0]          cfg_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DistW-1:0]         dist_sq,
  output logic [ParW-1:0]          s_param,
  output logic [ParW-1:0]          t_param
);
  localparam int F   = PARAM_FRAC_BITS;
  localparam int DL  = F + 1;
  localparam int NST = 7 + DL + 3;
  localparam int CW  = DiffW + F + 3;
  localparam int SQW = 2 * CW;

  logic [EpsW-1:0] eps;
  logic adv;
  logic [NST-1:0] vld;

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) eps <= '0;
    else if (cfg_valid) eps <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NST-2:0], in_valid};
  end
  assign out_valid = vld[NST-1];

  // stage 1: differences
  diff_t u1 [3], v1 [3], w1 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      u1[0] <= DiffW'(seg1_end_x) - DiffW'(seg1_start_x);
      u1[1] <= DiffW'(seg1_end_y) - DiffW'(seg1_start_y);
      u1[2] <= DiffW'(seg1_end_z) - DiffW'(seg1_start_z);
      v1[0] <= DiffW'(seg2_end_x) - DiffW'(seg2_start_x);
      v1[1] <= DiffW'(seg2_end_y) - DiffW'(seg2_start_y);
      v1[2] <= DiffW'(seg2_end_z) - DiffW'(seg2_start_z);
      w1[0] <= DiffW'(seg1_start_x) - DiffW'(seg2_start_x);
      w1[1] <= DiffW'(seg1_start_y) - DiffW'(seg2_start_y);
      w1[2] <= DiffW'(seg1_start_z) - DiffW'(seg2_start_z);
    end
  end

  // stage 2: dot products
  dot_t a2, b2, c2, d2, e2;
  diff_t u2 [3], v2 [3], w2 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      a2 <= DotW'(u1[0]*u1[0]) + DotW'(u1[1]*u1[1]) + DotW'(u1[2]*u1[2]);
      b2 <= DotW'(u1[0]*v1[0]) + DotW'(u1[1]*v1[1]) + DotW'(u1[2]*v1[2]);
      c2 <= DotW'(v1[0]*v1[0]) + DotW'(v1[1]*v1[1]) + DotW'(v1[2]*v1[2]);
      d2 <= DotW'(u1[0]*w1[0]) + DotW'(u1[1]*w1[1]) + DotW'(u1[2]*w1[2]);
      e2 <= DotW'(v1[0]*w1[0]) + DotW'(v1[1]*w1[1]) + DotW'(v1[2]*w1[2]);
      u2 <= u1; v2 <= v1; w2 <= w1;
    end
  end

  // stage 3: products of dots
  det_t ac3, bb3, be3, cd3, ae3, bd3;
  dot_t a3, b3, c3, d3, e3;
  diff_t u3 [3], v3 [3], w3 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      ac3 <= DetW'(a2) * DetW'(c2);
      bb3 <= DetW'(b2) * DetW'(b2);
      be3 <= DetW'(b2) * DetW'(e2);
      cd3 <= DetW'(c2) * DetW'(d2);
      ae3 <= DetW'(a2) * DetW'(e2);
      bd3 <= DetW'(b2) * DetW'(d2);
      a3 <= a2; b3 <= b2; c3 <= c2; d3 <= d2; e3 <= e2;
      u3 <= u2; v3 <= v2; w3 <= w2;
    end
  end

  // stage 4: determinant and numerators
  det_t dd4, sn4, tn4;
  dot_t a4, b4, c4, d4, e4;
  diff_t u4 [3], v4 [3], w4 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      dd4 <= ac3 - bb3;
      sn4 <= be3 - cd3;
      tn4 <= ae3 - bd3;
      a4 <= a3; b4 <= b3; c4 <= c3; d4 <= d3; e4 <= e3;
      u4 <= u3; v4 <= v3; w4 <= w3;
    end
  end

  // stage 5: first clamp
  det_t sn5, sd5, tn5, td5;
  dot_t a5, b5, d5;
  diff_t u5 [3], v5 [3], w5 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      if (near_zero(dd4, eps)) begin
        sn5 <= '0; sd5 <= DetW'(1); tn5 <= DetW'(e4); td5 <= DetW'(c4);
      end else if (sn4[DetW-1]) begin
        sn5 <= '0; sd5 <= dd4; tn5 <= DetW'(e4); td5 <= DetW'(c4);
      end else if (sn4 > dd4) begin
        sn5 <= dd4; sd5 <= dd4; tn5 <= DetW'(e4) + DetW'(b4); td5 <= DetW'(c4);
      end else begin
        sn5 <= sn4; sd5 <= dd4; tn5 <= tn4; td5 <= dd4;
      end
      a5 <= a4; b5 <= b4; d5 <= d4;
      u5 <= u4; v5 <= v4; w5 <= w4;
    end
  end

  // stage 6: second clamp
  det_t sn6, sd6, tn6, td6;
  diff_t u6 [3], v6 [3], w6 [3];
  det_t x5, sn6_next, sd6_next, tn6_next;
  logic tneg5, tbig5;
  always_comb begin
    tneg5 = tn5[DetW-1];
    tbig5 = tn5 > td5;
    x5 = tneg5 ? -DetW'(d5) : (DetW'(b5) - DetW'(d5));
    sn6_next = sn5;
    sd6_next = sd5;
    tn6_next = tn5;
    if (tneg5 || tbig5) begin
      tn6_next = tneg5 ? '0 : td5;
      if (x5[DetW-1]) sn6_next = '0;
      else if (x5 > DetW'(a5)) sn6_next = sd5;
      else begin
        sn6_next = x5; sd6_next = DetW'(a5);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sn6 <= sn6_next; sd6 <= sd6_next; tn6 <= tn6_next; td6 <= td5;
      u6 <= u5; v6 <= v5; w6 <= w5;
    end
  end

  // stage 7: zero tests, numerator scaling handled in divider by shift
  det_t sn7, sd7, tn7, td7;
  logic sz7, tz7;
  diff_t u7 [3], v7 [3], w7 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      sz7 <= near_zero(sn6, eps) || sn6[DetW-1] || sd6[DetW-1];
      tz7 <= near_zero(tn6, eps) || tn6[DetW-1] || td6[DetW-1];
      sn7 <= sn6; sd7 <= sd6; tn7 <= tn6; td7 <= td6;
      u7 <= u6; v7 <= v6; w7 <= w6;
    end
  end

  logic [F:0] sq, tq;
  ssd_div #(.FRAC(F)) u_sdiv (
    .clk(clk), .adv(adv), .num(sn7), .den(sd7), .zero(sz7), .quo(sq));
  ssd_div #(.FRAC(F)) u_tdiv (
    .clk(clk), .adv(adv), .num(tn7), .den(td7), .zero(tz7), .quo(tq));

  diff_t ud [DL+1][3], vd [DL+1][3], wd [DL+1][3];
  always_comb begin
    ud[0] = u7; vd[0] = v7; wd[0] = w7;
  end
  for (genvar i = 0; i < DL; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        ud[i+1] <= ud[i]; vd[i+1] <= vd[i]; wd[i+1] <= wd[i];
      end
    end
  end

  // stage A: products s*u, t*v
  logic signed [CW-1:0] su [3], tv [3], wf [3];
  logic [F:0] sqa, tqa;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        su[k] <= CW'($signed({1'b0, sq})) * CW'(ud[DL][k]);
        tv[k] <= CW'($signed({1'b0, tq})) * CW'(vd[DL][k]);
        wf[k] <= CW'(wd[DL][k]) <<< F;
      end
      sqa <= sq; tqa <= tq;
    end
  end

  // stage B: components squared
  logic [SQW-1:0] sqc [3];
  logic [F:0] sqb, tqb;
  logic signed [CW-1:0] cmp [3];
  logic [CW-1:0] mg [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cmp[k] = wf[k] + su[k] - tv[k];
      mg[k]  = cmp[k][CW-1] ? CW'(-cmp[k]) : CW'(cmp[k]);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) sqc[k] <= SQW'(mg[k]) * SQW'(mg[k]);
      sqb <= sqa; tqb <= tqa;
    end
  end

  // stage C: sum and output
  logic [SQW+1:0] acc;
  always_comb acc = (SQW+2)'(sqc[0]) + (SQW+2)'(sqc[1]) + (SQW+2)'(sqc[2]);
  always_ff @(posedge clk) begin
    if (adv) begin
      dist_sq <= DistW'(acc >> (2*F));
      s_param <= (sqb > (F+1)'(17'h1FFFF)) ? ParW'(17'h1FFFF) : ParW'(sqb);
      t_param <= (tqb > (F+1)'(17'h1FFFF)) ? ParW'(17'h1FFFF) : ParW'(tqb);
    end
  end
endmodule

### rtl/ssd_checker.sv
module ssd_checker import ssd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [ParW-1:0]  s_param,
  input logic [ParW-1:0]  t_param,
  input logic [DistW-1:0] dist_sq
);
  a_stall_only_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall)) else $error("stall without backpressure");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(dist_sq) && $stable(s_param)
      && $stable(t_param)))
    else $error("output changed under stall");
  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall) else $error("stall while empty");
endmodule

bind segment_segment_dist_sq_core ssd_checker u_ssd_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .s_param(s_param),
  .t_param(t_param), .dist_sq(dist_sq));

### tb/segment_segment_dist_sq_core_test.sv
module segment_segment_dist_sq_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssd_pkg::*;

  localparam int FracBits = 16;
  localparam int Latency = FracBits + 12;

  typedef struct {
    logic signed [15:0] c [12];
  } seg_pair_t;

  typedef struct {
    logic [DistW-1:0] dsq;
    logic [ParW-1:0]  s;
    logic [ParW-1:0]  t;
  } closest_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic cfg_valid, cfg_ready;
  logic [EpsW-1:0] cfg_data;
  logic signed [15:0] crd [12];
  logic [DistW-1:0] dist_sq;
  logic [ParW-1:0] s_param, t_param;

  segment_segment_dist_sq_core #(.PARAM_FRAC_BITS(FracBits)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .seg1_start_x(crd[0]), .seg1_start_y(crd[1]), .seg1_start_z(crd[2]),
    .seg1_end_x(crd[3]), .seg1_end_y(crd[4]), .seg1_end_z(crd[5]),
    .seg2_start_x(crd[6]), .seg2_start_y(crd[7]), .seg2_start_z(crd[8]),
    .seg2_end_x(crd[9]), .seg2_end_y(crd[10]), .seg2_end_z(crd[11]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .dist_sq(dist_sq), .s_param(s_param), .t_param(t_param)
  );

  seg_pair_t pending_q[$];
  closest_t  closest_q[$];
  logic [31:0] eps;
  int errors = 0;
  bit send_idle_en = 1, recv_idle_en = 1, hold_sender = 0;
  bit hold_recv = 0;
  int send_gap = 0, recv_gap = 0;

  function automatic bit is_tiny(logic signed [127:0] x, logic [31:0] ep);
    logic [127:0] m;
    m = x[127] ? -x : x;
    return m <= {96'b0, ep};
  endfunction

  function automatic logic [127:0] frac_div(logic signed [127:0] n,
                                            logic signed [127:0] dn);
    if (dn <= 0 || n < 0) return 0;
    return (n <<< FracBits) / dn;
  endfunction

  function automatic closest_t predict_closest(seg_pair_t p, logic [31:0] ep);
    logic signed [127:0] u[3], v[3], w[3];
    logic signed [127:0] a, b, c, d, e, dt, sn, sd, tn, td, x, comp, acc;
    logic [127:0] sq, tq;
    closest_t r;
    for (int k = 0; k < 3; k++) begin
      u[k] = 128'(p.c[3+k]) - 128'(p.c[k]);
      v[k] = 128'(p.c[9+k]) - 128'(p.c[6+k]);
      w[k] = 128'(p.c[k]) - 128'(p.c[6+k]);
    end
    a = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
    b = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    c = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    d = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
    e = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
    dt = a*c - b*b;
    if (is_tiny(dt, ep)) begin
      sn = 0; sd = 1; tn = e; td = c;
    end else begin
      sd = dt; td = dt;
      sn = b*e - c*d;
      tn = a*e - b*d;
      if (sn < 0) begin
        sn = 0; tn = e; td = c;
      end else if (sn > sd) begin
        sn = sd; tn = e + b; td = c;
      end
    end
    if (tn < 0 || tn > td) begin
      if (tn < 0) begin
        tn = 0; x = -d;
      end else begin
        tn = td; x = b - d;
      end
      if (x < 0) sn = 0;
      else if (x > a) sn = sd;
      else begin
        sn = x; sd = a;
      end
    end
    sq = is_tiny(sn, ep) ? 0 : frac_div(sn, sd);
    tq = is_tiny(tn, ep) ? 0 : frac_div(tn, td);
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      comp = (w[k] <<< FracBits) + $signed(sq) * u[k] - $signed(tq) * v[k];
      acc += comp * comp;
    end
    r.dsq = DistW'(acc >> (2*FracBits));
    r.s = sq > 128'h1FFFF ? 17'h1FFFF : sq[16:0];
    r.t = tq > 128'h1FFFF ? 17'h1FFFF : tq[16:0];
    return r;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(0, 16)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++) p.c[k] = rand_coord();
    if (mode == 0) begin
      for (int k = 0; k < 3; k++) p.c[9+k] = p.c[6+k] + (p.c[3+k] - p.c[k]);
    end else if (mode == 1) begin
      for (int k = 0; k < 3; k++) p.c[3+k] = p.c[k];
    end else if (mode == 2) begin
      for (int k = 0; k < 3; k++) p.c[9+k] = p.c[6+k];
    end else if (mode == 3) begin
      for (int k = 0; k < 12; k++) p.c[k] = 16'($urandom_range(0, 64)) - 16'sd32;
    end
    return p;
  endfunction

  function automatic seg_pair_t fill_pair(logic signed [15:0] val);
    seg_pair_t p;
    for (int k = 0; k < 12; k++) p.c[k] = val;
    return p;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        closest_q.push_back(predict_closest(pending_q.pop_front(), eps));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 0;
        end else if (send_idle_en && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 7);
          in_valid <= 0;
        end else if (!hold_sender && pending_q.size() > (in_valid && !in_stall ? 0 : 0)
                     && !(in_valid && !in_stall && pending_q.size() == 0)) begin
          in_valid <= 1;
          for (int k = 0; k < 12; k++) crd[k] <= pending_q[0].c[k];
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      recv_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (closest_q.size() == 0) begin
          $display("%t unexpected result dist %0d s %0d t %0d", $realtime,
                   dist_sq, s_param, t_param);
          errors++;
        end else begin
          closest_t ex;
          ex = closest_q.pop_front();
          if (ex.dsq !== dist_sq || ex.s !== s_param || ex.t !== t_param) begin
            $display("%t mismatch expected dist %0d s %0d t %0d actual %0d %0d %0d",
                     $realtime, ex.dsq, ex.s, ex.t, dist_sq, s_param, t_param);
            errors++;
          end
        end
      end
      if (hold_recv) begin
        out_stall <= 1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1;
      end else if (recv_idle_en && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 7);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || closest_q.size() > 0 || in_valid) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic write_eps(logic [31:0] val);
    cfg_valid <= 1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    eps = val;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] eps_set[5];
    eps_set = '{32'd0, 32'd1, 32'd1000, 32'h00FFFFFF, 32'hFFFFFFFF};
    rst = 1;
    cfg_valid = 0;
    cfg_data = 0;
    eps = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    pending_q.push_back(fill_pair(16'sh0000));
    pending_q.push_back(fill_pair(16'sh7FFF));
    pending_q.push_back(fill_pair(16'sh8000));
    begin
      seg_pair_t p;
      p = fill_pair(16'sh8000);
      p.c[3] = 16'sh7FFF; p.c[4] = 16'sh7FFF; p.c[5] = 16'sh7FFF;
      p.c[6] = 16'sh7FFF; p.c[7] = 16'sh8000;
      pending_q.push_back(p);
      p = fill_pair(16'sh7FFF);
      p.c[0] = 16'sh8000; p.c[9] = 16'sh8000; p.c[7] = 16'sh8000;
      pending_q.push_back(p);
      p = fill_pair(0);
      p.c[3] = 100; p.c[6] = 50; p.c[7] = -10; p.c[10] = 10; p.c[8] = 5; p.c[11] = 5;
      pending_q.push_back(p);
      p = fill_pair(0);
      p.c[3] = 100; p.c[6] = -50; p.c[7] = -10; p.c[10] = -20;
      pending_q.push_back(p);
      p = fill_pair(0);
      p.c[3] = 100; p.c[6] = 300; p.c[7] = 5; p.c[9] = 400; p.c[10] = 5;
      pending_q.push_back(p);
      p = fill_pair(0);
      p.c[3] = 10; p.c[6] = 20; p.c[7] = 3; p.c[8] = 30; p.c[11] = 40;
      pending_q.push_back(p);
    end
    for (int i = 0; i < 10; i++) pending_q.push_back(rand_pair());
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_eps(ph == 2 ? $urandom : eps_set[ph]);
      for (int i = 0; i < 360; i++) pending_q.push_back(rand_pair());
      if (ph == 1) begin
        hold_recv <= 1'b1;
        repeat (200) @(posedge clk);
        hold_recv <= 1'b0;
      end
      if (ph == 3) begin
        while (pending_q.size() > 180) @(posedge clk);
        hold_sender = 1;
        while (closest_q.size() > 0) @(posedge clk);
        repeat (5) @(posedge clk);
        hold_sender = 0;
      end
      drain();
    end

    write_eps(0);
    send_idle_en = 0;
    recv_idle_en = 0;
    for (int i = 0; i < 200; i++) pending_q.push_back(rand_pair());
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### sim.f
rtl/ssd_pkg.sv
rtl/ssd_div.sv
rtl/segment_segment_dist_sq_core.sv
rtl/ssd_checker.sv
tb/segment_segment_dist_sq_core_test.sv
